>>> sv/cfs_pkg.sv
// Shared types and constants for the cuckoo fingerprint set.
// Used by cfs_ctrl, cfs_dp and cuckoo_fingerprint_set_unit; depends on nothing.
`default_nettype none

package cfs_pkg;

  localparam int FP_W = 64;
  localparam int COUNT_W = 13;
  localparam int OUTCOME_W = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 7;
  localparam int LB_CFG_W = 4;
  localparam int NS_CFG_W = 3;
  localparam int MK_CFG_W = 7;
  localparam int STASH_DEPTH = 2;

  localparam int LOG_BUCKETS_MAX_DEF = 10;
  localparam int SLOTS_MAX_DEF = 4;

  localparam logic [LB_CFG_W-1:0] LB_RESET = 4'd10;
  localparam logic [NS_CFG_W-1:0] NS_RESET = 3'd2;
  localparam logic [MK_CFG_W-1:0] MK_RESET = 7'd20;
  localparam logic [LB_CFG_W-1:0] LB_MIN = 4'd4;
  localparam logic [NS_CFG_W-1:0] NS_MIN = 3'd2;
  localparam logic [MK_CFG_W-1:0] MK_MAX = 7'd64;

  localparam logic [CFG_IDX_W-1:0] REG_LOG_BUCKETS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOTS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_KICKS = 2'd2;

  localparam logic ACT_LOOKUP = 1'b0;
  localparam logic ACT_INSERT = 1'b1;

  localparam logic [OUTCOME_W-1:0] OUT_LOOKUP = 3'd0;
  localparam logic [OUTCOME_W-1:0] OUT_PRESENT = 3'd1;
  localparam logic [OUTCOME_W-1:0] OUT_STORED = 3'd2;
  localparam logic [OUTCOME_W-1:0] OUT_STASHED = 3'd3;
  localparam logic [OUTCOME_W-1:0] OUT_FAILED = 3'd4;

  typedef struct packed {
    logic            action;
    logic [FP_W-1:0] fingerprint;
  } cfs_in_t;

  typedef struct packed {
    logic                 present;
    logic [OUTCOME_W-1:0] outcome;
    logic [FP_W-1:0]      dropped_fingerprint;
    logic [COUNT_W-1:0]   table_count;
  } cfs_out_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_RD_A, ST_RD_B, ST_CAP, ST_EVAL,
    ST_KICK, ST_KRD, ST_KCAP, ST_KTRY, ST_RESP
  } cfs_state_t;

  typedef struct packed {
    logic clr_wr;
    logic accept;
    logic rd_a;
    logic rd_b;
    logic cap_b;
    logic eval;
    logic kick;
    logic krd;
    logic kcap;
    logic ktry;
    logic load_out;
  } cfs_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_insert;
    logic found;
    logic has_free;
    logic walk_free;
    logic last_step;
    logic out_free;
  } cfs_sts_t;

endpackage

`default_nettype wire

>>> sv/cuckoo_fingerprint_set_unit.sv
// Top level of the cuckoo fingerprint set: controller, datapath, ports.
// Depends on cfs_pkg, cfs_ctrl and cfs_dp.
//
// The input channel (in_valid, in_stall, in_word) carries one word per item: an
// action (lookup or insert) and a 64-bit fingerprint. The result channel
// (out_valid, out_stall, out_word) returns exactly one word per item, in order:
// present flag, outcome code, dropped fingerprint and the table count.
// Configuration registers are written through cfg_valid/cfg_ready with a
// register index and data; cfg_ready is always high, and writes are meant to
// happen only while the block is idle.
// Buckets are rows of one memory, read and written one row per cycle. For a
// lookup or a simple insert the controller reads both buckets, captures them,
// evaluates and loads the result register (RD_A, RD_B, CAP, EVAL, RESP), then
// returns to idle. Each eviction step of an insert walk writes the shifted
// bucket, reads the next bucket, captures it and tries it, and a worst-case
// insert makes max_kicks + 1 such steps. One item is in work at a time; the
// next item is taken while the last result word still waits.
// After reset a clearing pass writes every one of the 2**LOG_BUCKETS_MAX bucket
// rows with in_stall high; configuration writes are taken meanwhile.
// When out_stall holds the result register full, a finished item waits until
// the register frees up.
`default_nettype none

module cuckoo_fingerprint_set_unit #(
  parameter int LOG_BUCKETS_MAX = cfs_pkg::LOG_BUCKETS_MAX_DEF,
  parameter int SLOTS_MAX = cfs_pkg::SLOTS_MAX_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire cfs_pkg::cfs_in_t               in_word,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output cfs_pkg::cfs_out_t                   out_word,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [cfs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cfs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import cfs_pkg::*;

  cfs_cmd_t cmd;
  cfs_sts_t sts;
  logic cfg_we;

  // Registers may be written in any cycle.
  assign cfg_ready = 1'b1;
  assign cfg_we = cfg_valid & cfg_ready;

  cfs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  cfs_dp #(
    .LOG_BUCKETS_MAX (LOG_BUCKETS_MAX),
    .SLOTS_MAX       (SLOTS_MAX)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_word   (in_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  // Reset starts the clearing pass, so no item is taken right after it.
  a_reset_busy: assert property (@(posedge clk) $rose(rst_n) |-> in_stall)
    else $error("item taken during clearing pass");
  // Only a failed insert hands back a fingerprint.
  a_drop_only_failed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.outcome != OUT_FAILED |-> out_word.dropped_fingerprint == '0)
    else $error("dropped fingerprint on non-failed result");
  // For insert results, present and outcome agree.
  a_present_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.outcome != OUT_LOOKUP |-> out_word.present ==
      (out_word.outcome == OUT_PRESENT))
    else $error("present flag disagrees with outcome");

endmodule

`default_nettype wire

>>> sv/cfs_ctrl.sv
// Controller state machine of the cuckoo fingerprint set.
// Depends on cfs_pkg; drives the cfs_dp command strobes.
`default_nettype none

module cfs_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire cfs_pkg::cfs_sts_t sts,
  output cfs_pkg::cfs_cmd_t      cmd
);
  import cfs_pkg::*;

  cfs_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (sts.clr_last) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_valid) state_nxt = ST_RD_A;
      ST_RD_A:  state_nxt = ST_RD_B;
      ST_RD_B:  state_nxt = ST_CAP;
      ST_CAP:   state_nxt = ST_EVAL;
      ST_EVAL: begin
        if (!sts.is_insert || sts.found || sts.has_free) state_nxt = ST_RESP;
        else state_nxt = ST_KICK;
      end
      ST_KICK:  state_nxt = ST_KRD;
      ST_KRD:   state_nxt = ST_KCAP;
      ST_KCAP:  state_nxt = ST_KTRY;
      ST_KTRY: begin
        if (sts.walk_free || sts.last_step) state_nxt = ST_RESP;
        else state_nxt = ST_KICK;
      end
      ST_RESP:  if (sts.out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_CLEAR: cmd.clr_wr = 1'b1;
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.accept = in_valid;
      end
      ST_RD_A:  cmd.rd_a = 1'b1;
      ST_RD_B:  cmd.rd_b = 1'b1;
      ST_CAP:   cmd.cap_b = 1'b1;
      ST_EVAL:  cmd.eval = 1'b1;
      ST_KICK:  cmd.kick = 1'b1;
      ST_KRD:   cmd.krd = 1'b1;
      ST_KCAP:  cmd.kcap = 1'b1;
      ST_KTRY:  cmd.ktry = 1'b1;
      ST_RESP:  cmd.load_out = sts.out_free;
      default:  cmd = '0;
    endcase
  end

  a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd)) else $error("more than one command strobe");
  a_accept_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> in_stall) else $error("accepted while busy");
  a_walk_ends: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ktry && sts.last_step |=> state_r == ST_RESP)
    else $error("walk ran past its limit");

endmodule

`default_nettype wire

>>> sv/cfs_dp.sv
// Datapath of the cuckoo fingerprint set: bucket memory, stash, walk registers,
// configuration registers and the result register. Depends on cfs_pkg.
`default_nettype none

module cfs_dp #(
  parameter int LOG_BUCKETS_MAX = cfs_pkg::LOG_BUCKETS_MAX_DEF,
  parameter int SLOTS_MAX = cfs_pkg::SLOTS_MAX_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire cfs_pkg::cfs_cmd_t                   cmd,
  output cfs_pkg::cfs_sts_t                        sts,
  input  wire cfs_pkg::cfs_in_t                    in_word,
  input  wire logic                                cfg_we,
  input  wire logic [cfs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [cfs_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wire logic                                out_stall,
  output logic                                     out_valid,
  output cfs_pkg::cfs_out_t                        out_word
);
  import cfs_pkg::*;

  localparam int BW = LOG_BUCKETS_MAX;
  localparam int NB = 1 << LOG_BUCKETS_MAX;
  localparam int SW = (SLOTS_MAX > 1) ? $clog2(SLOTS_MAX) : 1;

  typedef logic [SLOTS_MAX-1:0][FP_W-1:0] row_t;

  row_t mem_r [NB];
  row_t q_r;

  logic [LB_CFG_W-1:0] lb_cfg_r;
  logic [NS_CFG_W-1:0] ns_cfg_r;
  logic [MK_CFG_W-1:0] mk_cfg_r;

  logic [BW-1:0] mask_r, h1_r, h2_r, cur_r, clr_r;
  logic [NS_CFG_W-1:0] ns_r;
  logic [MK_CFG_W-1:0] mk_r, step_r;
  logic [FP_W-1:0] fp_r;
  logic act_r;
  row_t row_r, b2_r;

  logic [FP_W-1:0] stash_r [STASH_DEPTH];
  logic [1:0] stash_fill_r;
  logic [COUNT_W-1:0] count_r;

  logic found_r;
  logic [OUTCOME_W-1:0] outcome_r;
  logic [FP_W-1:0] dropped_r;
  logic out_valid_r;
  cfs_out_t out_r;

  // Configuration clamp applied when an item is taken.
  logic [4:0] lb_eff;
  logic [BW-1:0] mask_nxt;
  logic [NS_CFG_W-1:0] ns_eff;
  logic [MK_CFG_W-1:0] mk_eff;

  always_comb begin
    if (lb_cfg_r < LB_MIN) lb_eff = 5'(LB_MIN);
    else if (int'(lb_cfg_r) > LOG_BUCKETS_MAX) lb_eff = 5'(LOG_BUCKETS_MAX);
    else lb_eff = {1'b0, lb_cfg_r};
    for (int i = 0; i < BW; i++) mask_nxt[i] = (i < int'(lb_eff));
    if (ns_cfg_r < NS_MIN) ns_eff = NS_MIN;
    else if (int'(ns_cfg_r) > SLOTS_MAX) ns_eff = NS_CFG_W'(SLOTS_MAX);
    else ns_eff = ns_cfg_r;
    mk_eff = (mk_cfg_r > MK_MAX) ? MK_MAX : mk_cfg_r;
  end

  // Match, free slot search and bucket shift.
  logic found;
  logic [FP_W-1:0] blank1, blank2, blankc;
  logic has_free, pick_side, walk_free;
  logic [SW-1:0] pick_s, walk_s;
  row_t shifted;

  always_comb begin
    found = 1'b0;
    for (int s = 0; s < SLOTS_MAX; s++) begin
      if (s < int'(ns_r) && (row_r[s] == fp_r || b2_r[s] == fp_r)) found = 1'b1;
    end
    if (stash_fill_r != 2'd0 && (stash_r[0] == fp_r || stash_r[1] == fp_r)) found = 1'b1;

    blank1 = (h1_r == '0) ? '1 : '0;
    blank2 = (h2_r == '0) ? '1 : '0;
    blankc = (cur_r == '0) ? '1 : '0;

    has_free = 1'b0;
    pick_side = 1'b0;
    pick_s = '0;
    walk_free = 1'b0;
    walk_s = '0;
    for (int s = SLOTS_MAX - 1; s >= 0; s--) begin
      if (s < int'(ns_r)) begin
        if (row_r[s] == blank1) begin
          has_free = 1'b1;
          pick_side = 1'b0;
          pick_s = SW'(s);
        end else if (b2_r[s] == blank2) begin
          has_free = 1'b1;
          pick_side = 1'b1;
          pick_s = SW'(s);
        end
        if (row_r[s] == blankc) begin
          walk_free = 1'b1;
          walk_s = SW'(s);
        end
      end
    end

    shifted = row_r;
    for (int s = 0; s < SLOTS_MAX; s++) begin
      if (s + 1 < int'(ns_r)) shifted[s] = row_r[s + 1];
      else if (s + 1 == int'(ns_r)) shifted[s] = fp_r;
    end
  end

  // Next bucket of the evicted word.
  logic [FP_W-1:0] evict_fp;
  logic [BW-1:0] alt_b, cur_nxt;

  always_comb begin
    evict_fp = row_r[0];
    alt_b = evict_fp[BW-1:0] & mask_r;
    cur_nxt = (cur_r == alt_b) ? (evict_fp[32 +: BW] & mask_r) : alt_b;
  end

  // Memory port selection.
  logic we, re;
  logic [BW-1:0] waddr, raddr;
  row_t wdata, wrow;

  always_comb begin
    we = 1'b0;
    waddr = cur_r;
    wrow = row_r;
    wdata = shifted;
    if (cmd.clr_wr) begin
      we = 1'b1;
      waddr = clr_r;
      wdata = (clr_r == '0) ? '1 : '0;
    end else if (cmd.eval && act_r && !found && has_free) begin
      we = 1'b1;
      waddr = pick_side ? h2_r : h1_r;
      wrow = pick_side ? b2_r : row_r;
      wrow[pick_s] = fp_r;
      wdata = wrow;
    end else if (cmd.kick) begin
      we = 1'b1;
      waddr = cur_r;
      wdata = shifted;
    end else if (cmd.ktry && walk_free) begin
      we = 1'b1;
      waddr = cur_r;
      wrow[walk_s] = fp_r;
      wdata = wrow;
    end
    re = cmd.rd_a | cmd.rd_b | cmd.krd;
    if (cmd.rd_a) raddr = h1_r;
    else if (cmd.rd_b) raddr = h2_r;
    else raddr = cur_r;
  end

  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    if (re) q_r <= mem_r[raddr];
  end

  // Control and state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lb_cfg_r <= LB_RESET;
      ns_cfg_r <= NS_RESET;
      mk_cfg_r <= MK_RESET;
      clr_r <= '0;
      stash_fill_r <= 2'd0;
      stash_r[0] <= '0;
      stash_r[1] <= '0;
      count_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_LOG_BUCKETS: lb_cfg_r <= cfg_data[LB_CFG_W-1:0];
          REG_SLOTS:       ns_cfg_r <= cfg_data[NS_CFG_W-1:0];
          REG_MAX_KICKS:   mk_cfg_r <= cfg_data[MK_CFG_W-1:0];
          default: ;
        endcase
      end
      if (cmd.clr_wr) clr_r <= clr_r + 1'b1;
      if (cmd.eval && act_r && !found) count_r <= count_r + 1'b1;
      if (cmd.ktry && !walk_free && sts.last_step) begin
        count_r <= count_r - 1'b1;
        if (stash_fill_r == 2'd0) begin
          stash_fill_r <= 2'd1;
          stash_r[0] <= fp_r;
          stash_r[1] <= fp_r;
        end else if (stash_fill_r == 2'd1) begin
          stash_fill_r <= 2'd2;
          stash_r[1] <= fp_r;
        end
      end
      if (cmd.load_out) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // Item registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      act_r <= in_word.action;
      fp_r <= in_word.fingerprint;
      mask_r <= mask_nxt;
      ns_r <= ns_eff;
      mk_r <= mk_eff;
      h1_r <= in_word.fingerprint[BW-1:0] & mask_nxt;
      h2_r <= in_word.fingerprint[32 +: BW] & mask_nxt;
    end
    if (cmd.rd_b || cmd.kcap) row_r <= q_r;
    if (cmd.cap_b) b2_r <= q_r;
    if (cmd.eval) begin
      found_r <= found;
      dropped_r <= '0;
      cur_r <= h1_r;
      step_r <= '0;
      if (act_r == ACT_LOOKUP) outcome_r <= OUT_LOOKUP;
      else if (found) outcome_r <= OUT_PRESENT;
      else outcome_r <= OUT_STORED;
    end
    if (cmd.kick) begin
      fp_r <= evict_fp;
      cur_r <= cur_nxt;
    end
    if (cmd.ktry) begin
      if (walk_free) begin
        outcome_r <= OUT_STORED;
      end else if (sts.last_step) begin
        if (stash_fill_r == 2'd2) begin
          outcome_r <= OUT_FAILED;
          dropped_r <= fp_r;
        end else begin
          outcome_r <= OUT_STASHED;
        end
      end else begin
        step_r <= step_r + 1'b1;
      end
    end
    if (cmd.load_out) begin
      out_r.present <= found_r;
      out_r.outcome <= outcome_r;
      out_r.dropped_fingerprint <= dropped_r;
      out_r.table_count <= count_r;
    end
  end

  always_comb begin
    sts.clr_last = (clr_r == '1);
    sts.is_insert = (act_r == ACT_INSERT);
    sts.found = found;
    sts.has_free = has_free;
    sts.walk_free = walk_free;
    sts.last_step = (step_r == mk_r);
    sts.out_free = !out_valid_r || !out_stall;
  end

  assign out_valid = out_valid_r;
  assign out_word = out_r;

  a_stash_fill: assert property (@(posedge clk) disable iff (!rst_n)
    stash_fill_r != 2'd3) else $error("stash fill out of range");
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ktry |-> step_r <= mk_r) else $error("walk step past limit");
  a_single_write: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_wr |-> !(cmd.kick || cmd.eval))
    else $error("write during clearing pass");

endmodule

`default_nettype wire
